// ===== rtl/bmphv_pkg.sv =====
// ----------------------------------------------------------------------------
// bmphv_pkg
// Types and constants shared by the bmp header validator modules.
// ----------------------------------------------------------------------------
package bmphv_pkg;

    localparam int          HDR_BYTES   = 54;
    localparam int          CNT_W       = 6;
    localparam int          DIM_W       = 31;

    localparam logic [7:0]  MAGIC_B     = 8'h42;
    localparam logic [7:0]  MAGIC_M     = 8'h4D;
    localparam logic [31:0] MIN_SIZE    = 32'd54;
    localparam logic [31:0] MAX_COMP    = 32'd5;
    localparam logic [15:0] PLANES_ONE  = 16'd1;
    localparam logic [DIM_W-1:0] MAX_DIM_RESET = 31'd100000;

    // register index of max_dimension, taken from paddr above the byte lanes
    localparam logic        REG_MAX_DIM = 1'b0;

    // byte positions of the header fields
    localparam logic [CNT_W-1:0] IDX_MAGIC_B = 6'd0;
    localparam logic [CNT_W-1:0] IDX_MAGIC_M = 6'd1;
    localparam logic [CNT_W-1:0] IDX_SIZE    = 6'd2;
    localparam logic [CNT_W-1:0] IDX_RSVD    = 6'd6;
    localparam logic [CNT_W-1:0] IDX_OFFSET  = 6'd10;
    localparam logic [CNT_W-1:0] IDX_DIB     = 6'd14;
    localparam logic [CNT_W-1:0] IDX_WIDTH   = 6'd18;
    localparam logic [CNT_W-1:0] IDX_HEIGHT  = 6'd22;
    localparam logic [CNT_W-1:0] IDX_FORMAT  = 6'd26;
    localparam logic [CNT_W-1:0] IDX_FMT_END = 6'd33;
    localparam logic [CNT_W-1:0] IDX_LAST    = 6'(HDR_BYTES - 1);

    typedef struct packed {
        logic [31:0] size;
        logic [31:0] offset;
        logic [31:0] dib;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] comp;
        logic [15:0] bpp;
        logic [15:0] planes;
    } t_hdr_fields;

endpackage

// ===== rtl/bmphv_judge.sv =====
// ----------------------------------------------------------------------------
// bmphv_judge
// Verdict logic over the gathered header fields; all checks run in parallel.
// ----------------------------------------------------------------------------
module bmphv_judge (
    input  bmphv_pkg::t_hdr_fields          i_fields,
    input  logic                            i_early_fail,
    input  logic [bmphv_pkg::DIM_W-1:0]     i_max_dim,
    output logic                            o_ok
);

    logic [31:0] max_dim;
    logic [31:0] height_mag;
    logic        size_ok;
    logic        dib_ok;
    logic        bpp_ok;
    logic        width_ok;
    logic        height_ok;
    logic        fmt_ok;

    assign max_dim    = {1'b0, i_max_dim};
    assign height_mag = i_fields.height[31] ? (~i_fields.height + 32'd1) : i_fields.height;

    assign size_ok = (i_fields.size >= bmphv_pkg::MIN_SIZE)
                  && (i_fields.offset >= bmphv_pkg::MIN_SIZE)
                  && (i_fields.offset < i_fields.size)
                  && (i_fields.dib < i_fields.size);

    assign dib_ok = (i_fields.dib == 32'd12)  || (i_fields.dib == 32'd40)
                 || (i_fields.dib == 32'd52)  || (i_fields.dib == 32'd56)
                 || (i_fields.dib == 32'd64)  || (i_fields.dib == 32'd108)
                 || (i_fields.dib == 32'd124);

    assign bpp_ok = (i_fields.bpp == 16'd1)  || (i_fields.bpp == 16'd4)
                 || (i_fields.bpp == 16'd8)  || (i_fields.bpp == 16'd16)
                 || (i_fields.bpp == 16'd24) || (i_fields.bpp == 16'd32);

    assign fmt_ok = (i_fields.planes == bmphv_pkg::PLANES_ONE)
                 && (i_fields.comp <= bmphv_pkg::MAX_COMP);

    assign width_ok  = !i_fields.width[31] && (i_fields.width != 32'd0)
                    && (i_fields.width <= max_dim);
    assign height_ok = (i_fields.height != 32'd0) && (height_mag <= max_dim);

    assign o_ok = !i_early_fail && size_ok && dib_ok && bpp_ok && fmt_ok
               && width_ok && height_ok;

endmodule

// ===== rtl/bmp_header_validator.sv =====
// ----------------------------------------------------------------------------
// bmp_header_validator
// Gathers the 54-byte bmp file header one byte per item and gives a verdict.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry one file byte per item with
// first and last marks. An item with i_first_byte starts a new header; items
// outside a header are dropped without a result.
// Output channel: o_out_valid / i_out_ready carry one verdict item with the
// declared file size (zero on a reject), given on header byte 53, or a reject
// when a byte marked last ends the header early.
// Throughput is one item per cycle while o_in_ready is high: each byte only
// updates the byte counter and the field registers, and the verdict checks
// run in parallel off them. Each result is registered before o_out_valid.
// A two-entry output stage (output register plus skid register) keeps the
// input open while a result waits; o_in_ready drops only when both hold one.
// Reset (synchronous, active low) leaves no header open, empties the output
// stage and sets max_dimension to 100000. max_dimension is written through
// the APB port at address 0.
// ----------------------------------------------------------------------------
module bmp_header_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_verdict,
    output logic [31:0] o_decl_size,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [bmphv_pkg::DIM_W-1:0] r_max_dim;

    logic                        r_active;
    logic                        n_active;
    logic [bmphv_pkg::CNT_W-1:0] r_count;
    logic [bmphv_pkg::CNT_W-1:0] n_count;
    logic                        r_early_fail;
    logic                        n_early_fail;
    bmphv_pkg::t_hdr_fields      r_hdr;
    bmphv_pkg::t_hdr_fields      n_hdr;

    logic        r_out_valid;
    logic        r_out_verdict;
    logic [31:0] r_out_size;
    logic        r_skid_valid;
    logic        r_skid_verdict;
    logic [31:0] r_skid_size;

    logic                        in_acc;
    logic                        drain;
    logic                        cfg_wr;
    logic                        work;
    logic [bmphv_pkg::CNT_W-1:0] idx;
    logic [bmphv_pkg::CNT_W-1:0] off;
    logic                        judge_ok;
    logic                        res_valid;
    logic                        res_verdict;
    logic [31:0]                 res_size;

    assign in_acc = i_in_valid && o_in_ready;
    assign drain  = r_out_valid && i_out_ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bmphv_pkg::REG_MAX_DIM) ? {1'b0, r_max_dim} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dim <= bmphv_pkg::MAX_DIM_RESET;
        end else if (cfg_wr && (paddr[2] == bmphv_pkg::REG_MAX_DIM)) begin
            r_max_dim <= pwdata[bmphv_pkg::DIM_W-1:0];
        end
    end

    // byte gathering
    assign work = in_acc && (i_first_byte || r_active);
    assign idx  = i_first_byte ? '0 : r_count;

    always_comb begin
        n_active     = r_active;
        n_count      = r_count;
        n_early_fail = r_early_fail;
        n_hdr        = r_hdr;
        off          = '0;
        if (work) begin
            if (i_first_byte) begin
                n_early_fail = 1'b0;
                n_hdr        = '0;
            end
            n_active = 1'b1;
            n_count  = idx + 6'd1;
            if (idx == bmphv_pkg::IDX_MAGIC_B) begin
                if (i_data_byte != bmphv_pkg::MAGIC_B) n_early_fail = 1'b1;
            end else if (idx == bmphv_pkg::IDX_MAGIC_M) begin
                if (i_data_byte != bmphv_pkg::MAGIC_M) n_early_fail = 1'b1;
            end else if (idx < bmphv_pkg::IDX_RSVD) begin
                off = idx - bmphv_pkg::IDX_SIZE;
                n_hdr.size[8*off[1:0] +: 8] = i_data_byte;
            end else if (idx < bmphv_pkg::IDX_OFFSET) begin
                if (i_data_byte != 8'd0) n_early_fail = 1'b1;
            end else if (idx < bmphv_pkg::IDX_DIB) begin
                off = idx - bmphv_pkg::IDX_OFFSET;
                n_hdr.offset[8*off[1:0] +: 8] = i_data_byte;
            end else if (idx < bmphv_pkg::IDX_WIDTH) begin
                off = idx - bmphv_pkg::IDX_DIB;
                n_hdr.dib[8*off[1:0] +: 8] = i_data_byte;
            end else if (idx < bmphv_pkg::IDX_HEIGHT) begin
                off = idx - bmphv_pkg::IDX_WIDTH;
                n_hdr.width[8*off[1:0] +: 8] = i_data_byte;
            end else if (idx < bmphv_pkg::IDX_FORMAT) begin
                off = idx - bmphv_pkg::IDX_HEIGHT;
                n_hdr.height[8*off[1:0] +: 8] = i_data_byte;
            end else if (idx <= bmphv_pkg::IDX_FMT_END) begin
                // planes, bpp, then compression as one little-endian run
                off = idx - bmphv_pkg::IDX_FORMAT;
                case (off[2:0])
                    3'd0: n_hdr.planes[7:0]  = i_data_byte;
                    3'd1: n_hdr.planes[15:8] = i_data_byte;
                    3'd2: n_hdr.bpp[7:0]     = i_data_byte;
                    3'd3: n_hdr.bpp[15:8]    = i_data_byte;
                    3'd4: n_hdr.comp[7:0]    = i_data_byte;
                    3'd5: n_hdr.comp[15:8]   = i_data_byte;
                    3'd6: n_hdr.comp[23:16]  = i_data_byte;
                    3'd7: n_hdr.comp[31:24]  = i_data_byte;
                    default: n_hdr.planes    = r_hdr.planes;
                endcase
            end
            if ((idx == bmphv_pkg::IDX_LAST) || i_last_byte) begin
                n_active = 1'b0;
            end
        end
    end

    // header bytes past the format fields never touch the fields, so the
    // verdict on the final byte reads the stored values
    bmphv_judge u_judge (
        .i_fields     (r_hdr),
        .i_early_fail (r_early_fail),
        .i_max_dim    (r_max_dim),
        .o_ok         (judge_ok)
    );

    always_comb begin
        res_valid   = 1'b0;
        res_verdict = 1'b0;
        res_size    = 32'd0;
        if (work) begin
            if (idx == bmphv_pkg::IDX_LAST) begin
                res_valid   = 1'b1;
                res_verdict = judge_ok;
                res_size    = judge_ok ? r_hdr.size : 32'd0;
            end else if (i_last_byte) begin
                res_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_count      <= '0;
            r_early_fail <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_count      <= n_count;
            r_early_fail <= n_early_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    // output register with skid entry
    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out_verdict;
    assign o_decl_size = r_out_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (drain) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || drain) begin
            r_out_valid <= res_valid;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (drain) begin
                r_out_verdict <= r_skid_verdict;
                r_out_size    <= r_skid_size;
            end
        end else if (!r_out_valid || drain) begin
            r_out_verdict <= res_verdict;
            r_out_size    <= res_size;
        end else if (res_valid) begin
            r_skid_verdict <= res_verdict;
            r_skid_size    <= res_size;
        end
    end

    // checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_count_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_count <= bmphv_pkg::IDX_LAST))
        else $error("byte counter ran past the header");

    a_result_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> !r_active)
        else $error("header still open after its result");

    a_reject_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_verdict) |-> (r_out_size == 32'd0))
        else $error("reject item carries a file size");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bmp_header_validator.
// Candidate headers go in one byte per item under random valid/ready idling.
// A behavioral copy of the header rules, or a directed row's typed verdict,
// predicts each verdict, and every output item is checked in order against
// it. max_dimension is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          N_PHASES     = 6;
    localparam int          N_DIRECTED   = 27;
    localparam logic [2:0]  ADDR_MAX_DIM = {bmphv_pkg::REG_MAX_DIM, 2'b00};
    localparam logic [5:0]  FULL         = 6'(bmphv_pkg::HDR_BYTES);
    localparam logic [5:0]  NO_LAST      = 6'd63;
    localparam logic [15:0] MAGIC_OK     = {bmphv_pkg::MAGIC_M, bmphv_pkg::MAGIC_B};

    localparam bmphv_pkg::t_hdr_fields BASE_HDR = '{size: 32'd1000, offset: 32'd54,
                                                    dib: 32'd40, width: 32'd100,
                                                    height: 32'd100, comp: 32'd0,
                                                    bpp: 16'd24, planes: 16'd1};
    localparam logic [31:0] DIB_SIZES [7] = '{32'd12, 32'd40, 32'd52, 32'd56, 32'd64,
                                              32'd108, 32'd124};
    localparam logic [15:0] BPP_SIZES [6] = '{16'd1, 16'd4, 16'd8, 16'd16, 16'd24, 16'd32};

    // which field of the good header a directed row overrides
    typedef enum logic [3:0] {
        SEL_NONE, SEL_MAGIC_B, SEL_MAGIC_M, SEL_RSVD, SEL_SIZE, SEL_OFFSET,
        SEL_DIB, SEL_WIDTH, SEL_HEIGHT, SEL_PLANES, SEL_BPP, SEL_COMP
    } t_fsel;

    typedef struct packed {
        t_fsel       sel;
        logic [31:0] val;
        logic [5:0]  n_bytes;
        logic [5:0]  last_at;
        logic        noise;
        logic        restart;
        logic        trail;
        logic        chk;
        logic        exp_ok;
        logic [31:0] exp_size;
    } t_case;

    typedef struct packed {
        logic        ok;
        logic [31:0] size;
    } t_verdict;

    // sel, value, bytes, last at, noise, restart, trailing, typed, verdict, size
    t_case dir_tab [N_DIRECTED] = '{
        '{SEL_NONE,   32'd0,          FULL,  NO_LAST, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 32'd1000},
        '{SEL_MAGIC_B, 32'h43,        FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_MAGIC_M, 32'h4C,        FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_RSVD,   32'h0001_0000,  FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_SIZE,   32'hFFFF_FFFF,  FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
          32'hFFFF_FFFF},
        '{SEL_SIZE,   32'd54,         FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_SIZE,   32'd0,          FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_OFFSET, 32'd53,         FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_OFFSET, 32'd999,        FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{SEL_DIB,    32'd124,        FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{SEL_DIB,    32'd13,         FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_PLANES, 32'h0101,       FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_BPP,    32'd32,         FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{SEL_BPP,    32'd2,          FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_COMP,   32'd5,          FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{SEL_COMP,   32'd6,          FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_WIDTH,  32'd100000,     FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{SEL_WIDTH,  32'd100001,     FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_WIDTH,  32'd0,          FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_WIDTH,  32'h8000_0000,  FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_HEIGHT, 32'hFFFE_7960,  FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
        '{SEL_HEIGHT, 32'd0,          FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_HEIGHT, 32'h8000_0000,  FULL,  NO_LAST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_NONE,   32'd0,          6'd30, 6'd29,   1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_NONE,   32'd0,          6'd1,  6'd0,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0},
        '{SEL_NONE,   32'd0,          FULL,  6'd53,   1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 32'd1000},
        '{SEL_NONE,   32'd0,          FULL,  NO_LAST, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 32'd1000}
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_first_byte = 1'b0;
    logic        i_last_byte  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic        o_verdict;
    logic [31:0] o_decl_size;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [bmphv_pkg::DIM_W-1:0] max_lim   = bmphv_pkg::MAX_DIM_RESET;
    logic [5:0]                  hdr_pos   = '0;
    logic                        in_hdr    = 1'b0;
    bmphv_pkg::t_hdr_fields      hdr       = '0;
    logic                        bad_early = 1'b0;
    t_verdict                    verdict_q [$];
    logic                        use_typed     = 1'b0;
    t_verdict                    typed_verdict = '0;

    logic [7:0]  img [bmphv_pkg::HDR_BYTES];
    logic        quiet_in  = 1'b0;
    logic        quiet_out = 1'b0;
    int          n_bytes   = 0;
    int          n_judged  = 0;
    int          n_ok      = 0;
    int          n_rej     = 0;
    int          n_cfg     = 0;
    int          mism      = 0;
    int          cycles    = 0;

    bmp_header_validator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (o_verdict),
        .o_decl_size  (o_decl_size),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic header_ok();
        logic [31:0] lim;
        logic [31:0] abs_h;
        lim   = {1'b0, max_lim};
        abs_h = hdr.height[31] ? -hdr.height : hdr.height;
        if (bad_early) return 1'b0;
        if (hdr.size < bmphv_pkg::MIN_SIZE || hdr.offset < bmphv_pkg::MIN_SIZE)
            return 1'b0;
        if (hdr.offset >= hdr.size || hdr.dib >= hdr.size) return 1'b0;
        if (!(hdr.dib inside {32'd12, 32'd40, 32'd52, 32'd56, 32'd64, 32'd108, 32'd124}))
            return 1'b0;
        if (hdr.planes != bmphv_pkg::PLANES_ONE) return 1'b0;
        if (!(hdr.bpp inside {16'd1, 16'd4, 16'd8, 16'd16, 16'd24, 16'd32})) return 1'b0;
        if (hdr.comp > bmphv_pkg::MAX_COMP) return 1'b0;
        if (hdr.width[31] || hdr.width == 32'd0 || hdr.width > lim) return 1'b0;
        if (hdr.height == 32'd0 || abs_h > lim) return 1'b0;
        return 1'b1;
    endfunction

    // update the header image for one accepted item, queue its verdict if any
    task automatic track_byte(input logic [7:0] b, input logic is_first, input logic is_last);
        int       p;
        t_verdict v;
        n_bytes++;
        if (is_first) begin
            in_hdr    = 1'b1;
            hdr_pos   = '0;
            hdr       = '0;
            bad_early = 1'b0;
        end
        if (in_hdr) begin
            p = int'(hdr_pos);
            if (p == int'(bmphv_pkg::IDX_MAGIC_B)) begin
                if (b != bmphv_pkg::MAGIC_B) bad_early = 1'b1;
            end else if (p == int'(bmphv_pkg::IDX_MAGIC_M)) begin
                if (b != bmphv_pkg::MAGIC_M) bad_early = 1'b1;
            end else if (p < int'(bmphv_pkg::IDX_RSVD)) begin
                hdr.size[8*(p-int'(bmphv_pkg::IDX_SIZE)) +: 8] = b;
            end else if (p < int'(bmphv_pkg::IDX_OFFSET)) begin
                if (b != 8'h00) bad_early = 1'b1;
            end else if (p < int'(bmphv_pkg::IDX_DIB)) begin
                hdr.offset[8*(p-int'(bmphv_pkg::IDX_OFFSET)) +: 8] = b;
            end else if (p < int'(bmphv_pkg::IDX_WIDTH)) begin
                hdr.dib[8*(p-int'(bmphv_pkg::IDX_DIB)) +: 8] = b;
            end else if (p < int'(bmphv_pkg::IDX_HEIGHT)) begin
                hdr.width[8*(p-int'(bmphv_pkg::IDX_WIDTH)) +: 8] = b;
            end else if (p < int'(bmphv_pkg::IDX_FORMAT)) begin
                hdr.height[8*(p-int'(bmphv_pkg::IDX_HEIGHT)) +: 8] = b;
            end else if (p < int'(bmphv_pkg::IDX_FORMAT) + 2) begin
                hdr.planes[8*(p-int'(bmphv_pkg::IDX_FORMAT)) +: 8] = b;
            end else if (p < int'(bmphv_pkg::IDX_FORMAT) + 4) begin
                hdr.bpp[8*(p-int'(bmphv_pkg::IDX_FORMAT)-2) +: 8] = b;
            end else if (p <= int'(bmphv_pkg::IDX_FMT_END)) begin
                hdr.comp[8*(p-int'(bmphv_pkg::IDX_FORMAT)-4) +: 8] = b;
            end
            hdr_pos = hdr_pos + 6'd1;
            if (hdr_pos == FULL || is_last) begin
                v.ok   = (hdr_pos == FULL) && header_ok();
                v.size = v.ok ? hdr.size : 32'd0;
                in_hdr = 1'b0;
                verdict_q.push_back(use_typed ? typed_verdict : v);
                n_judged++;
            end
        end
    endtask

    // called at a rising edge; returns at the edge that accepts the item
    task automatic push_byte(input logic [7:0] b, input logic is_first, input logic is_last);
        while (!quiet_in && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_data_byte  <= b;
        i_first_byte <= is_first;
        i_last_byte  <= is_last;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        track_byte(b, is_first, is_last);
    endtask

    task automatic send_image(input int n, input int last_at);
        for (int i = 0; i < n; i++) begin
            push_byte(img[i], i == 0, i == last_at);
        end
    endtask

    task automatic build_image(input bmphv_pkg::t_hdr_fields f, input logic [15:0] mg,
                               input logic [31:0] rs);
        for (int i = int'(bmphv_pkg::IDX_FMT_END) + 1; i < bmphv_pkg::HDR_BYTES; i++) begin
            img[i] = 8'($urandom);
        end
        img[int'(bmphv_pkg::IDX_MAGIC_B)] = mg[7:0];
        img[int'(bmphv_pkg::IDX_MAGIC_M)] = mg[15:8];
        for (int i = 0; i < 4; i++) begin
            img[int'(bmphv_pkg::IDX_SIZE) + i]       = f.size[8*i +: 8];
            img[int'(bmphv_pkg::IDX_RSVD) + i]       = rs[8*i +: 8];
            img[int'(bmphv_pkg::IDX_OFFSET) + i]     = f.offset[8*i +: 8];
            img[int'(bmphv_pkg::IDX_DIB) + i]        = f.dib[8*i +: 8];
            img[int'(bmphv_pkg::IDX_WIDTH) + i]      = f.width[8*i +: 8];
            img[int'(bmphv_pkg::IDX_HEIGHT) + i]     = f.height[8*i +: 8];
            img[int'(bmphv_pkg::IDX_FORMAT) + 4 + i] = f.comp[8*i +: 8];
        end
        for (int i = 0; i < 2; i++) begin
            img[int'(bmphv_pkg::IDX_FORMAT) + i]     = f.planes[8*i +: 8];
            img[int'(bmphv_pkg::IDX_FORMAT) + 2 + i] = f.bpp[8*i +: 8];
        end
    endtask

    // width or height magnitude, biased to the edges of the current limit
    function automatic logic [31:0] pick_dim();
        logic [31:0] top;
        top = (max_lim == '0) ? 32'd1 : {1'b0, max_lim};
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return top;
            2:       return top + 32'd1;
            3:       return 32'h8000_0000;
            4:       return $urandom;
            default: return (top == 32'd1) ? 32'd1 : $urandom_range(top, 1);
        endcase
    endfunction

    task automatic rand_header(output bmphv_pkg::t_hdr_fields f, output logic [15:0] mg,
                               output logic [31:0] rs);
        case ($urandom_range(9))
            0:       f.size = 32'd0;
            1:       f.size = bmphv_pkg::MIN_SIZE;
            2:       f.size = bmphv_pkg::MIN_SIZE + 32'd1;
            3:       f.size = $urandom;
            default: f.size = $urandom_range(4000000, 200);
        endcase
        if (f.size > bmphv_pkg::MIN_SIZE && $urandom_range(99) < 85) begin
            f.offset = $urandom_range(f.size - 32'd1, bmphv_pkg::MIN_SIZE);
        end else begin
            case ($urandom_range(2))
                0:       f.offset = bmphv_pkg::MIN_SIZE - 32'd1;
                1:       f.offset = f.size;
                default: f.offset = $urandom;
            endcase
        end
        f.dib    = ($urandom_range(99) < 88) ? DIB_SIZES[$urandom_range(6)]
                                             : 32'($urandom_range(200));
        f.planes = ($urandom_range(99) < 90) ? bmphv_pkg::PLANES_ONE : 16'($urandom);
        f.bpp    = ($urandom_range(99) < 90) ? BPP_SIZES[$urandom_range(5)]
                                             : 16'($urandom_range(40));
        f.comp   = ($urandom_range(99) < 85) ? 32'($urandom_range(5))
                                             : (($urandom_range(1) == 0) ? 32'd6 : $urandom);
        f.width  = pick_dim();
        f.height = pick_dim();
        if ($urandom_range(1) == 1) f.height = -f.height;
        mg = ($urandom_range(99) < 95) ? MAGIC_OK : 16'($urandom);
        rs = ($urandom_range(99) < 95) ? 32'd0 : (32'd1 << $urandom_range(31));
    endtask

    task automatic write_max_dim(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_DIM;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_lim = value[bmphv_pkg::DIM_W-1:0];
        n_cfg++;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= quiet_out || ($urandom_range(99) >= 31);
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                mism++;
                if (mism <= 10)
                    $display("unexpected verdict item: verdict=%0b size=%0d",
                             o_verdict, o_decl_size);
            end else begin
                want = verdict_q.pop_front();
                if (o_verdict !== want.ok || o_decl_size !== want.size) begin
                    mism++;
                    if (mism <= 10)
                        $display("mismatch: expected verdict=%0b size=%0d, got %0b %0d",
                                 want.ok, want.size, o_verdict, o_decl_size);
                end else if (want.ok) begin
                    n_ok++;
                end else begin
                    n_rej++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout: %0d verdicts still outstanding", verdict_q.size());
            $display("[bmp_header_validator] ERROR");
            $finish;
        end
    end

    initial begin
        bmphv_pkg::t_hdr_fields f;
        logic [15:0] mg;
        logic [31:0] rs;
        logic [31:0] phase_val [N_PHASES];
        t_case       c;
        int          base_bytes;
        int          base_judged;
        int          kind;
        int          len;

        phase_val[0] = 32'd1;
        phase_val[1] = 32'hFFFF_FFFF;
        phase_val[2] = 32'd0;
        phase_val[3] = 32'($urandom_range(4000, 2));
        phase_val[4] = $urandom;
        phase_val[5] = 32'($urandom_range(300000, 1000));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed headers at the reset value of max_dimension
        for (int r = 0; r < N_DIRECTED; r++) begin
            c  = dir_tab[r];
            f  = BASE_HDR;
            mg = MAGIC_OK;
            rs = '0;
            case (c.sel)
                SEL_MAGIC_B: mg[7:0]  = c.val[7:0];
                SEL_MAGIC_M: mg[15:8] = c.val[7:0];
                SEL_RSVD:    rs       = c.val;
                SEL_SIZE:    f.size   = c.val;
                SEL_OFFSET:  f.offset = c.val;
                SEL_DIB:     f.dib    = c.val;
                SEL_WIDTH:   f.width  = c.val;
                SEL_HEIGHT:  f.height = c.val;
                SEL_PLANES:  f.planes = c.val[15:0];
                SEL_BPP:     f.bpp    = c.val[15:0];
                SEL_COMP:    f.comp   = c.val;
                default: ;
            endcase
            build_image(f, mg, rs);
            // stray bytes outside any header, one carrying last
            if (c.noise) begin
                push_byte(8'hA5, 1'b0, 1'b0);
                push_byte(8'h5A, 1'b0, 1'b1);
            end
            // open a header and abandon it with a fresh first
            if (c.restart) send_image(20, int'(NO_LAST));
            use_typed     = c.chk;
            typed_verdict = '{ok: c.exp_ok, size: c.exp_size};
            send_image(int'(c.n_bytes), int'(c.last_at));
            use_typed = 1'b0;
            if (c.trail) begin
                push_byte(8'hFF, 1'b0, 1'b0);
                push_byte(8'h42, 1'b0, 1'b1);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // drain before touching the register
            i_in_valid <= 1'b0;
            while (verdict_q.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            write_max_dim(phase_val[ph]);
            quiet_in    = (ph == 1);
            quiet_out   = (ph == 1);
            base_bytes  = n_bytes;
            base_judged = n_judged;
            while (n_bytes - base_bytes < 40 || n_judged - base_judged < 1) begin
                rand_header(f, mg, rs);
                build_image(f, mg, rs);
                kind = int'($urandom_range(99));
                if (kind < 70) begin
                    send_image(bmphv_pkg::HDR_BYTES,
                               ($urandom_range(3) == 0) ? bmphv_pkg::HDR_BYTES - 1
                                                        : int'(NO_LAST));
                    repeat ($urandom_range(3))
                        push_byte(8'($urandom), 1'b0, $urandom_range(3) == 0);
                end else if (kind < 80) begin
                    len = int'($urandom_range(53, 1));
                    send_image(len, len - 1);
                end else if (kind < 90) begin
                    send_image(int'($urandom_range(53, 1)), int'(NO_LAST));
                end else begin
                    repeat ($urandom_range(6, 1))
                        push_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
                end
            end
            // finish on a whole header so nothing is left open
            if (in_hdr) begin
                rand_header(f, mg, rs);
                build_image(f, mg, rs);
                send_image(bmphv_pkg::HDR_BYTES, int'(NO_LAST));
            end
        end

        i_in_valid <= 1'b0;
        quiet_out = 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d bytes and %0d verdicts (%0d accepted, %0d rejected)",
                 n_bytes, n_judged, n_ok, n_rej);
        $display("max_dimension rewritten %0d times, %0d mismatching items", n_cfg, mism);
        if (mism == 0 && verdict_q.size() == 0) begin
            $display("[bmp_header_validator] OK");
        end else begin
            $display("[bmp_header_validator] ERROR");
        end
        $finish;
    end

endmodule
